### rtl/core/cfkb_pkg.sv
// Shared types, codes and defaults of the clipped fill and keyed blit engine.
package cfkb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;

  localparam int COORD_W = 12;
  localparam int SIZE_W  = 11;
  localparam int PIX_W   = 16;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    ACT_FILL  = 2'd0,
    ACT_BLIT  = 2'd1,
    ACT_SRC   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // Operations of the shared address unit.
  typedef enum logic [1:0] {
    AOP_HOLD = 2'd0,
    AOP_LOAD = 2'd1,
    AOP_INC  = 2'd2,
    AOP_ROW  = 2'd3
  } addr_op_t;

endpackage

### rtl/core/cfkb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfkb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/cfkb_addr_unit.sv
// Shared frame address unit: load row*width+column, step a pixel or step a row.
module cfkb_addr_unit
  import cfkb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                                          clk,
  input  addr_op_t                                      op,
  input  logic [$clog2(SCREEN_WIDTH)-1:0]               col,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0]              row,
  output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0] addr
);

  localparam int AW = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam logic [AW-1:0] STRIDE = AW'(SCREEN_WIDTH);

  logic [AW-1:0] addr_r;
  logic [AW-1:0] line_r;
  logic [AW-1:0] load_val;
  logic [AW-1:0] row_val;

  assign load_val = AW'(row) * STRIDE + AW'(col);
  assign row_val  = line_r + STRIDE;

  always_ff @(posedge clk) begin
    unique case (op)
      AOP_LOAD: begin
        addr_r <= load_val;
        line_r <= load_val;
      end
      AOP_INC: begin
        addr_r <= addr_r + AW'(1);
      end
      AOP_ROW: begin
        addr_r <= row_val;
        line_r <= row_val;
      end
      default: begin
      end
    endcase
  end

  assign addr = addr_r;

endmodule

### rtl/core/clipped_fill_and_keyed_blit_core.sv
// Top level of the clipped fill and keyed blit framebuffer engine.
//
// Commands arrive on the in_ stream, one request per handshake, with the
// command code in in_tuser. Every request returns exactly one result on the
// out_ stream, in order. in_tready is high only while the sequencer is idle.
// Steps from acceptance to the result being loaded into the output register:
//   blit start, ignored or skipped source pixel, off-screen read: result only
//   stored source pixel: address load, frame write, result
//   read: address load, RAM read, result
//   fill: address load, a frame write per covered pixel, result; or result only
//         when nothing is covered; one frame write per cycle, the single write port sets this.
// The result waits in an output register; a new request is accepted while it
// waits, and the sequencer holds in its result step until the receiver takes
// the previous one. Reset clears the blit state and the output valid; the
// frame store is not cleared, and software clears the screen with a
// full-screen fill before reading it.
module clipped_fill_and_keyed_blit_core
  import cfkb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x[11:0], pos_y[23:12], rect_width[34:24], rect_height[45:35],
  // color[61:46], key_enable[62], key_color[78:63], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_data[15:0], pixel_written[16], blit_done[17], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam logic signed [12:0] SW13 = 13'(SCREEN_WIDTH);
  localparam logic signed [12:0] SH13 = 13'(SCREEN_HEIGHT);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ADDR   = 6'b000010,
    ST_FILL   = 6'b000100,
    ST_WRITE  = 6'b001000,
    ST_RDREQ  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // request fields
  action_t                     in_act;
  logic signed [COORD_W-1:0]   in_px, in_py;
  logic [SIZE_W-1:0]           in_w, in_h;
  logic [PIX_W-1:0]            in_color, in_key;
  logic                        in_ken;
  logic                        accept;

  assign in_act   = action_t'(in_tuser);
  assign in_px    = in_tdata[11:0];
  assign in_py    = in_tdata[23:12];
  assign in_w     = in_tdata[34:24];
  assign in_h     = in_tdata[45:35];
  assign in_color = in_tdata[61:46];
  assign in_ken   = in_tdata[62];
  assign in_key   = in_tdata[78:63];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // blit state
  logic signed [COORD_W-1:0] blit_x_r, blit_y_r;
  logic [SIZE_W-1:0]         blit_w_r, blit_h_r;
  logic [SIZE_W-1:0]         src_col_r, src_row_r;
  logic                      key_en_r;
  logic [PIX_W-1:0]          key_color_r;

  // working registers
  action_t           act_r;
  logic [XW-1:0]     col_r, x0_r, xlast_r;
  logic [YW-1:0]     row_r, ylast_r;
  logic [PIX_W-1:0]  color_r;
  logic              res_wr_r, res_done_r, rd_sel_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // fill clipping
  logic signed [12:0] px13, py13, xe, ye, fx0, fy0, fx1, fy1;
  logic               fill_any;

  assign px13 = {in_px[COORD_W-1], in_px};
  assign py13 = {in_py[COORD_W-1], in_py};
  assign xe   = px13 + $signed({2'b00, in_w});
  assign ye   = py13 + $signed({2'b00, in_h});
  assign fx0  = (px13 < 0) ? 13'sd0 : px13;
  assign fy0  = (py13 < 0) ? 13'sd0 : py13;
  assign fx1  = (xe > SW13) ? SW13 : xe;
  assign fy1  = (ye > SH13) ? SH13 : ye;
  assign fill_any = (fx0 < fx1) && (fy0 < fy1);

  logic signed [12:0] fx1m, fy1m;
  assign fx1m = fx1 - 13'sd1;
  assign fy1m = fy1 - 13'sd1;

  // read on-screen check
  logic rd_on;
  assign rd_on = (px13 >= 0) && (px13 < SW13) && (py13 >= 0) && (py13 < SH13);

  // source pixel placement
  logic signed [12:0] dx, dy;
  logic               src_pend, src_on, src_transp, src_wr, col_wrap, src_last;
  logic [SIZE_W:0]    col_inc, row_inc;

  assign dx = {blit_x_r[COORD_W-1], blit_x_r} + $signed({2'b00, src_col_r});
  assign dy = {blit_y_r[COORD_W-1], blit_y_r} + $signed({2'b00, src_row_r});
  assign src_pend   = (blit_w_r != '0) && (blit_h_r != '0) && (src_row_r < blit_h_r);
  assign src_on     = (dx >= 0) && (dx < SW13) && (dy >= 0) && (dy < SH13);
  assign src_transp = key_en_r && (in_color == key_color_r);
  assign src_wr     = src_pend && src_on && !src_transp;
  assign col_inc    = {1'b0, src_col_r} + 12'd1;
  assign row_inc    = {1'b0, src_row_r} + 12'd1;
  assign col_wrap   = (col_inc >= {1'b0, blit_w_r});
  assign src_last   = col_wrap && (row_inc >= {1'b0, blit_h_r});

  // address unit and frame store
  addr_op_t          aop;
  logic [AW-1:0]     addr;
  logic [PIX_W-1:0]  rd_data;
  logic              fill_row_end, fill_end;

  assign fill_row_end = (col_r == xlast_r);
  assign fill_end     = fill_row_end && (row_r == ylast_r);

  always_comb begin
    aop = AOP_HOLD;
    if (state_r == ST_ADDR) begin
      aop = AOP_LOAD;
    end else if (state_r == ST_FILL) begin
      if (!fill_row_end) begin
        aop = AOP_INC;
      end else if (!fill_end) begin
        aop = AOP_ROW;
      end
    end
  end

  cfkb_addr_unit #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_addr (
    .clk  (clk),
    .op   (aop),
    .col  (col_r),
    .row  (row_r),
    .addr (addr)
  );

  cfkb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk     (clk),
    .wr_en   ((state_r == ST_FILL) || (state_r == ST_WRITE)),
    .wr_addr (addr),
    .wr_data (color_r),
    .rd_en   (state_r == ST_RDREQ),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_act)
            ACT_FILL: state_nxt = fill_any ? ST_ADDR : ST_RESULT;
            ACT_BLIT: state_nxt = ST_RESULT;
            ACT_SRC:  state_nxt = src_wr ? ST_ADDR : ST_RESULT;
            ACT_READ: state_nxt = rd_on ? ST_ADDR : ST_RESULT;
            default:  state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_ADDR: begin
        unique case (act_r)
          ACT_FILL: state_nxt = ST_FILL;
          ACT_READ: state_nxt = ST_RDREQ;
          default:  state_nxt = ST_WRITE;
        endcase
      end
      ST_FILL:   if (fill_end) state_nxt = ST_RESULT;
      ST_WRITE:  state_nxt = ST_RESULT;
      ST_RDREQ:  state_nxt = ST_RESULT;
      ST_RESULT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      blit_x_r     <= '0;
      blit_y_r     <= '0;
      blit_w_r     <= '0;
      blit_h_r     <= '0;
      src_col_r    <= '0;
      src_row_r    <= '0;
      key_en_r     <= 1'b0;
      key_color_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RESULT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (accept && in_act == ACT_BLIT) begin
        blit_x_r    <= in_px;
        blit_y_r    <= in_py;
        blit_w_r    <= in_w;
        blit_h_r    <= in_h;
        src_col_r   <= '0;
        src_row_r   <= '0;
        key_en_r    <= in_ken;
        key_color_r <= in_key;
      end
      if (accept && in_act == ACT_SRC && src_pend) begin
        if (col_wrap) begin
          src_col_r <= '0;
          src_row_r <= row_inc[SIZE_W-1:0];
        end else begin
          src_col_r <= col_inc[SIZE_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= in_act;
      color_r    <= in_color;
      res_wr_r   <= 1'b0;
      res_done_r <= 1'b0;
      rd_sel_r   <= 1'b0;
      unique case (in_act)
        ACT_FILL: begin
          col_r   <= fx0[XW-1:0];
          row_r   <= fy0[YW-1:0];
          x0_r    <= fx0[XW-1:0];
          xlast_r <= fx1m[XW-1:0];
          ylast_r <= fy1m[YW-1:0];
        end
        ACT_SRC: begin
          col_r      <= dx[XW-1:0];
          row_r      <= dy[YW-1:0];
          res_wr_r   <= src_wr;
          res_done_r <= src_pend && src_last;
        end
        ACT_READ: begin
          col_r    <= px13[XW-1:0];
          row_r    <= py13[YW-1:0];
          rd_sel_r <= rd_on;
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_FILL && fill_row_end && !fill_end) begin
      col_r <= x0_r;
      row_r <= row_r + YW'(1);
    end else if (state_r == ST_FILL && !fill_row_end) begin
      col_r <= col_r + XW'(1);
    end
    if (state_r == ST_RESULT && out_free) begin
      out_tdata_r <= {6'b000000, res_done_r, res_wr_r, rd_sel_r ? rd_data : 16'h0000};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### tb/clipped_fill_and_keyed_blit_core_test.sv
`timescale 1ns / 100ps
// Self-checking stream testbench: directed table, then random draw traffic, against a shadow frame.
module clipped_fill_and_keyed_blit_core_test;
  import cfkb_pkg::*;

  localparam int SW          = SCREEN_WIDTH_DEF;
  localparam int SH          = SCREEN_HEIGHT_DEF;
  localparam int N_RANDOM    = 1200;
  localparam int QUIET_LIMIT = 300000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    action_t     act;
    logic [11:0] x;
    logic [11:0] y;
    logic [10:0] w;
    logic [10:0] h;
    logic [15:0] color;
    logic        key_en;
    logic [15:0] key;
  } draw_cmd_t;

  typedef struct packed {
    logic [15:0] rd;
    logic        wr;
    logic        done;
  } draw_res_t;

  typedef struct packed {
    draw_cmd_t c;
    logic      chk;
    draw_res_t r;
  } dir_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  clipped_fill_and_keyed_blit_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // Shadow of the engine: frame contents and blit progress.
  logic [15:0] shadow_fb [0:SW*SH-1];
  int          org_x, org_y, blit_w, blit_h, src_col, src_row;
  logic        key_on;
  logic [15:0] key_val;
  bit          last_ignored;

  draw_res_t   due_results [$];
  dir_row_t    directed_rows [$];
  int          n_errors     = 0;
  int          issued       = 0;
  int          gap_pct      = 0;
  int          stall_pct    = 0;
  int          stall_left   = 0;
  int          quiet_cycles = 0;

  function automatic draw_cmd_t mk(action_t act, int x, int y, int w, int h, int color,
                                   int ken, int key);
    draw_cmd_t c;
    c.act    = act;
    c.x      = x[11:0];
    c.y      = y[11:0];
    c.w      = w[10:0];
    c.h      = h[10:0];
    c.color  = color[15:0];
    c.key_en = ken[0];
    c.key    = key[15:0];
    return c;
  endfunction

  // Advance the shadow by one request and return the result it must produce.
  function automatic draw_res_t apply_draw_cmd(draw_cmd_t c);
    draw_res_t r;
    int px, py, wi, hi, x0, y0, x1, y1, xx, yy, dx, dy;
    r            = '0;
    last_ignored = 1'b0;
    px           = $signed(c.x);
    py           = $signed(c.y);
    wi           = c.w;
    hi           = c.h;
    case (c.act)
      ACT_FILL: begin
        x0 = (px < 0) ? 0 : px;
        y0 = (py < 0) ? 0 : py;
        x1 = px + wi;
        y1 = py + hi;
        if (x1 > SW) x1 = SW;
        if (y1 > SH) y1 = SH;
        for (yy = y0; yy < y1; yy++)
          for (xx = x0; xx < x1; xx++)
            shadow_fb[yy*SW + xx] = c.color;
      end
      ACT_BLIT: begin
        org_x   = px;
        org_y   = py;
        blit_w  = wi;
        blit_h  = hi;
        src_col = 0;
        src_row = 0;
        key_on  = c.key_en;
        key_val = c.key;
      end
      ACT_SRC: begin
        if (blit_w != 0 && blit_h != 0 && src_row < blit_h) begin
          dx = org_x + src_col;
          dy = org_y + src_row;
          if (dx >= 0 && dx < SW && dy >= 0 && dy < SH &&
              !(key_on && c.color == key_val)) begin
            shadow_fb[dy*SW + dx] = c.color;
            r.wr = 1'b1;
          end
          // off-screen pixels still advance the image position
          if (src_col + 1 >= blit_w) begin
            src_col = 0;
            src_row++;
            if (src_row >= blit_h) r.done = 1'b1;
          end else begin
            src_col++;
          end
        end else begin
          last_ignored = 1'b1;
        end
      end
      ACT_READ: begin
        if (px >= 0 && px < SW && py >= 0 && py < SH) r.rd = shadow_fb[py*SW + px];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  task automatic issue_cmd(draw_cmd_t c, logic chk, draw_res_t typed);
    draw_res_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, c.key, c.key_en, c.color, c.h, c.w, c.y, c.x};
    in_tuser  <= c.act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_draw_cmd(c);
    if (!last_ignored) issued++;
    due_results.push_back(chk ? typed : r);
  endtask

  task automatic add_row(action_t act, int x, int y, int w, int h, int color, int ken,
                         int key, logic chk, int rd, int wr, int done);
    dir_row_t row;
    row.c      = mk(act, x, y, w, h, color, ken, key);
    row.chk    = chk;
    row.r.rd   = rd[15:0];
    row.r.wr   = wr[0];
    row.r.done = done[0];
    directed_rows.push_back(row);
  endtask

  // Receiver: random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check each result against the oldest one due.
  always @(posedge clk) begin : result_check
    draw_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        if (out_tdata[15:0] !== want.rd) begin
          $error("read_data: expected %h, got %h", want.rd, out_tdata[15:0]);
          n_errors++;
        end
        if (out_tdata[16] !== want.wr) begin
          $error("pixel_written: expected %b, got %b", want.wr, out_tdata[16]);
          n_errors++;
        end
        if (out_tdata[17] !== want.done) begin
          $error("blit_done: expected %b, got %b", want.done, out_tdata[17]);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results due", quiet_cycles,
               due_results.size());
        $display("** clipped_fill_and_keyed_blit_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int          k, n, npix, bw, bh, pick, next_phase;
    logic [15:0] kc;
    int          ken;

    org_x   = 0;
    org_y   = 0;
    blit_w  = 0;
    blit_h  = 0;
    src_col = 0;
    src_row = 0;
    key_on  = 1'b0;
    key_val = '0;

    // act, x, y, w, h, color, ken, key, typed, rd, wr, done
    add_row(ACT_SRC,     0,     0,    0,    0, 'h1234, 0,      0, 1,      0, 0, 0);
    add_row(ACT_FILL,    0,     0,   SW,   SH, 'h0000, 0,      0, 1,      0, 0, 0);
    add_row(ACT_READ,    0,     0,    0,    0,      0, 0,      0, 1,      0, 0, 0);
    add_row(ACT_FILL, -2048, -2048, 2047, 2047, 'hFFFF, 0,      0, 1,      0, 0, 0);
    add_row(ACT_FILL,  -100,   -50, 2047, 2047, 'hFFFF, 1, 'hFFFF, 1,      0, 0, 0);
    add_row(ACT_READ,  SW-1,  SH-1,    0,    0,      0, 0,      0, 1, 'hFFFF, 0, 0);
    add_row(ACT_READ,    -1,     0,    0,    0,      0, 0,      0, 1,      0, 0, 0);
    add_row(ACT_READ,  2047, -2048, 2047, 2047, 'hFFFF, 1, 'hFFFF, 1,      0, 0, 0);
    add_row(ACT_FILL,    10,    10,    0,    5, 'h0000, 0,      0, 1,      0, 0, 0);
    add_row(ACT_FILL,     5,     6,    3,    2, 'h5555, 0,      0, 1,      0, 0, 0);
    add_row(ACT_READ,     7,     7,    0,    0,      0, 0,      0, 0,      0, 0, 0);
    // keyed blit that hangs off the right edge
    add_row(ACT_BLIT,  SW-2,  SH-2,    3,    2,      0, 1, 'hF800, 1,      0, 0, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'h0001, 0,      0, 1,      0, 1, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'hF800, 0,      0, 1,      0, 0, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'h0002, 0,      0, 1,      0, 0, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'h0003, 0,      0, 1,      0, 1, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'hF800, 0,      0, 1,      0, 0, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'h0004, 0,      0, 1,      0, 0, 1);
    add_row(ACT_SRC,      0,     0,    0,    0, 'h0009, 0,      0, 1,      0, 0, 0);
    add_row(ACT_READ,  SW-1,  SH-2,    0,    0,      0, 0,      0, 0,      0, 0, 0);
    // abandon a blit, then key match with keying off still writes
    add_row(ACT_BLIT,    -1,    -1,    2,    2,      0, 0, 'h0007, 1,      0, 0, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'h0007, 0,      0, 1,      0, 0, 0);
    add_row(ACT_BLIT,     0,  SH-1,    1,    1,      0, 0, 'h0007, 1,      0, 0, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'h0007, 0,      0, 1,      0, 1, 1);
    add_row(ACT_READ,     0,  SH-1,    0,    0,      0, 0,      0, 1, 'h0007, 0, 0);
    add_row(ACT_BLIT,   100,   100,    0, 2047,      0, 1, 'hFFFF, 1,      0, 0, 0);
    add_row(ACT_SRC,      0,     0,    0,    0, 'hFFFF, 0,      0, 1,      0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 20;
    stall_pct = 20;
    for (k = 0; k < directed_rows.size(); k++)
      issue_cmd(directed_rows[k].c, directed_rows[k].chk, directed_rows[k].r);

    issued     = 0;
    next_phase = 0;
    while (issued < N_RANDOM) begin
      if (issued >= N_RANDOM - 150) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (issued >= next_phase) begin
        gap_pct    = pick_level();
        stall_pct  = pick_level();
        next_phase = next_phase + 100;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // well-formed blit near the screen, sometimes cut short
        case ($urandom_range(0, 3))
          0: kc = 16'h0000;
          1: kc = 16'hFFFF;
          2: kc = 16'hF81F;
          default: kc = $urandom_range(0, 65535);
        endcase
        ken  = $urandom_range(0, 1);
        bw   = $urandom_range(1, 10);
        bh   = $urandom_range(1, 8);
        issue_cmd(mk(ACT_BLIT, int'($urandom_range(0, 344)) - 14,
                     int'($urandom_range(0, 264)) - 14, bw, bh,
                     $urandom_range(0, 65535), ken, kc), 1'b0, '0);
        npix = bw * bh;
        if ($urandom_range(0, 7) == 0) npix = $urandom_range(0, npix - 1);
        for (n = 0; n < npix; n++)
          issue_cmd(mk(ACT_SRC, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 2047), $urandom_range(0, 2047),
                       ($urandom_range(0, 3) == 0) ? int'(kc) : $urandom_range(0, 65535),
                       $urandom_range(0, 1), $urandom_range(0, 65535)), 1'b0, '0);
        if ($urandom_range(0, 9) == 0)
          issue_cmd(mk(ACT_SRC, 0, 0, 0, 0, $urandom_range(0, 65535), 0, 0), 1'b0, '0);
      end else if (pick < 65) begin
        // mostly small fills, now and then the full field range
        if ($urandom_range(0, 59) == 0)
          issue_cmd(mk(ACT_FILL, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 2047), $urandom_range(0, 2047),
                       $urandom_range(0, 65535), $urandom_range(0, 1),
                       $urandom_range(0, 65535)), 1'b0, '0);
        else
          issue_cmd(mk(ACT_FILL, int'($urandom_range(0, 350)) - 20,
                       int'($urandom_range(0, 270)) - 20, $urandom_range(0, 24),
                       $urandom_range(0, 24), $urandom_range(0, 65535), 0, 0), 1'b0, '0);
      end else if (pick < 90) begin
        if ($urandom_range(0, 7) == 0)
          issue_cmd(mk(ACT_READ, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 2047), $urandom_range(0, 2047),
                       $urandom_range(0, 65535), $urandom_range(0, 1),
                       $urandom_range(0, 65535)), 1'b0, '0);
        else
          issue_cmd(mk(ACT_READ, int'($urandom_range(0, 327)) - 4,
                       int'($urandom_range(0, 247)) - 4, 0, 0, 0, 0, 0), 1'b0, '0);
      end else begin
        // noise: blit start over the whole field range, a few pixels or none
        issue_cmd(mk(ACT_BLIT, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 2047), $urandom_range(0, 2047),
                     $urandom_range(0, 65535), $urandom_range(0, 1),
                     $urandom_range(0, 65535)), 1'b0, '0);
        npix = $urandom_range(0, 3);
        for (n = 0; n < npix; n++)
          issue_cmd(mk(ACT_SRC, 0, 0, 0, 0, $urandom_range(0, 65535), 0, 0), 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("** clipped_fill_and_keyed_blit_core: PASSED **");
    end else begin
      $display("** clipped_fill_and_keyed_blit_core: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/cfkb_pkg.sv
rtl/core/cfkb_ram.sv
rtl/core/cfkb_addr_unit.sv
rtl/core/clipped_fill_and_keyed_blit_core.sv
tb/clipped_fill_and_keyed_blit_core_test.sv
